[rtl/mips_subset_instruction_executor_macros.svh]
// Assertion macros used by the executor top module.
// Needs signals named clk and arst_n in the scope where a macro is used.
`ifndef MIPS_SUBSET_INSTRUCTION_EXECUTOR_MACROS_SVH
`define MIPS_SUBSET_INSTRUCTION_EXECUTOR_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checked only while out of reset.
`define MSE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define MSE_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MSE_ASSERT(lbl, prop, msg)
`define MSE_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[rtl/mse_pkg.sv]
// Package of the instruction executor: operation codes, word types, sizes.
// Used by every module of the block; depends on nothing.
`default_nettype none

package mse_pkg;

	localparam int WORD_W        = 32;
	localparam int LINE_W        = 16;
	localparam int REG_COUNT     = 32;
	localparam int REG_ADDR_W    = $clog2(REG_COUNT);
	localparam int MEM_WORDS_DEF = 8192;

	localparam logic [REG_ADDR_W-1:0] RETURN_REG = REG_ADDR_W'(31);

	typedef enum logic [4:0] {
		FN_ADD   = 5'd0,
		FN_SUB   = 5'd1,
		FN_OR    = 5'd2,
		FN_AND   = 5'd3,
		FN_XOR   = 5'd4,
		FN_NOR   = 5'd5,
		FN_SLLV  = 5'd6,
		FN_SRLV  = 5'd7,
		FN_SLT   = 5'd8,
		FN_ADDI  = 5'd9,
		FN_ANDI  = 5'd10,
		FN_ORI   = 5'd11,
		FN_XORI  = 5'd12,
		FN_NORI  = 5'd13,
		FN_SLL   = 5'd14,
		FN_SRL   = 5'd15,
		FN_SLTIU = 5'd16,
		FN_J     = 5'd17,
		FN_JR    = 5'd18,
		FN_JAL   = 5'd19,
		FN_BEQ   = 5'd20,
		FN_BNE   = 5'd21,
		FN_LB    = 5'd22,
		FN_SB    = 5'd23,
		FN_LABEL = 5'd24
	} func_t;

	typedef struct packed {
		logic [4:0]               func;
		logic [REG_ADDR_W-1:0]    dest_reg;
		logic [REG_ADDR_W-1:0]    src_a;
		logic [REG_ADDR_W-1:0]    src_b;
		logic signed [WORD_W-1:0] immediate;
		logic [LINE_W-1:0]        target_line;
	} instr_t;

	typedef struct packed {
		logic [LINE_W-1:0]        next_line;
		logic                     wrote_register;
		logic signed [WORD_W-1:0] written_value;
		logic                     finished;
		logic                     error_code;
	} result_t;

	// Register file write port.
	typedef struct packed {
		logic                  en;
		logic [REG_ADDR_W-1:0] addr;
		logic [WORD_W-1:0]     data;
	} rf_wr_t;

	// What the execute logic decides for one instruction.
	typedef struct packed {
		logic [LINE_W-1:0]     next_line;
		logic                  wr;
		logic [REG_ADDR_W-1:0] wreg;
		logic [WORD_W-1:0]     val;
		logic                  mem_rd;
		logic                  mem_wr;
		logic                  err;
	} exec_t;

endpackage

`default_nettype wire

[rtl/mips_subset_instruction_executor.sv]
// Executor for a small MIPS-like integer subset, one pre-decoded line per input word.
// Depends on mse_pkg, mse_regfile, mse_alu and the assertion macro header.
//
// Channels: instr_valid/instr_stall/instr carry one instruction word, and
// result_valid/result_stall/result carry one result word per instruction. A word
// moves at a clock edge where valid is high and stall is low. The one register,
// program_length, is to be written by the user through cfg_wr_en/cfg_wr_data only
// while the block is idle; the block itself does not enforce this.
// Pipeline: the register file is read at acceptance (stage 1 gets the operands,
// forwarded from the instruction ahead), stage 1 executes and issues the data
// memory access, stage 2 writes the register file and loads the output register.
// One instruction is accepted per cycle while instr_stall is low, bounded by the
// single register file write port.
//
// Reset clears the registers, the line index and program_length, then the data
// memory is cleared one word a cycle, word 0 to MEM_WORDS-1, with instr_stall high.
// When result_stall holds, the output register keeps its word and the stages behind
// fill up; instr_stall rises only once both stages are full.
`default_nettype none
`include "mips_subset_instruction_executor_macros.svh"

module mips_subset_instruction_executor
	import mse_pkg::*;
#(
	parameter int MEM_WORDS = MEM_WORDS_DEF
)
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              instr_valid,
	output logic                   instr_stall,
	input  wire instr_t            instr,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output result_t                result,
	input  wire logic              cfg_wr_en,
	input  wire logic [LINE_W-1:0] cfg_wr_data
);

	localparam int ADDR_W = $clog2(MEM_WORDS);

	// Control
	logic              clr_busy_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic [LINE_W-1:0] line_q;
	logic [LINE_W-1:0] prog_len_q;
	logic              accept, s2_free, en_s2, out_ready, en_out;

	// Stage 1
	logic              valid_s1;
	instr_t            instr_s1;
	logic [WORD_W-1:0] rf_a, rf_b, op_a, op_b;
	logic [REG_ADDR_W-1:0] rb_sel, rb_sel_s1;
	exec_t             ex;

	// Stage 2
	logic                  valid_s2;
	logic [LINE_W-1:0]     next_s2;
	logic                  wr_s2, load_s2, fin_s2, err_s2;
	logic [REG_ADDR_W-1:0] wreg_s2;
	logic [WORD_W-1:0]     val_s2, dmem_s2, wval_s2;

	// Output
	logic    result_valid_q;
	result_t result_q;

	rf_wr_t            rf_wr;
	logic [WORD_W-1:0] dmem [MEM_WORDS];
	logic              dm_we;
	logic [ADDR_W-1:0] dm_waddr;
	logic [WORD_W-1:0] dm_wdata;

	assign out_ready   = !result_valid_q || !result_stall;
	assign en_out      = valid_s2 && out_ready;
	assign s2_free     = !valid_s2 || out_ready;
	assign en_s2       = valid_s1 && s2_free;
	assign instr_stall = clr_busy_q || (valid_s1 && !s2_free);
	assign accept      = instr_valid && !instr_stall;

	// A store reads its data register through the second port.
	assign rb_sel    = (instr.func == FN_SB) ? instr.dest_reg : instr.src_b;
	assign rb_sel_s1 = (instr_s1.func == FN_SB) ? instr_s1.dest_reg : instr_s1.src_b;

	assign wval_s2 = load_s2 ? dmem_s2 : val_s2;

	assign rf_wr.en   = en_out && wr_s2;
	assign rf_wr.addr = wreg_s2;
	assign rf_wr.data = wval_s2;

	mse_regfile u_regfile (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.ra_addr (instr.src_a),
		.rb_addr (rb_sel),
		.ra_data (rf_a),
		.rb_data (rf_b),
		.wr      (rf_wr)
	);

	// The instruction in stage 2 has not written yet; its value overrides the file.
	always_comb begin
		op_a = rf_a;
		op_b = rf_b;
		if (valid_s2 && wr_s2 && (wreg_s2 == instr_s1.src_a)) begin
			op_a = wval_s2;
		end
		if (valid_s2 && wr_s2 && (wreg_s2 == rb_sel_s1)) begin
			op_b = wval_s2;
		end
	end

	mse_alu #(
		.MEM_WORDS (MEM_WORDS)
	) u_alu (
		.instr (instr_s1),
		.a     (op_a),
		.b     (op_b),
		.line  (line_q),
		.ex    (ex)
	);

	assign dm_we    = clr_busy_q || (en_s2 && ex.mem_wr);
	assign dm_waddr = clr_busy_q ? clr_addr_q : op_a[ADDR_W-1:0];
	assign dm_wdata = clr_busy_q ? '0 : op_b;

	always_ff @(posedge clk) begin
		if (dm_we) begin
			dmem[dm_waddr] <= dm_wdata;
		end
		if (en_s2 && ex.mem_rd) begin
			dmem_s2 <= dmem[op_a[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + ADDR_W'(1);
			if (clr_addr_q == ADDR_W'(MEM_WORDS - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prog_len_q <= '0;
		end else if (cfg_wr_en) begin
			prog_len_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			result_valid_q <= 1'b0;
			line_q         <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (en_s2) begin
				valid_s1 <= 1'b0;
			end
			if (en_s2) begin
				valid_s2 <= 1'b1;
				line_q   <= ex.next_line;
			end else if (en_out) begin
				valid_s2 <= 1'b0;
			end
			if (en_out) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			instr_s1 <= instr;
		end
		if (en_s2) begin
			next_s2 <= ex.next_line;
			wr_s2   <= ex.wr;
			wreg_s2 <= ex.wreg;
			val_s2  <= ex.val;
			load_s2 <= ex.mem_rd;
			fin_s2  <= (ex.next_line == prog_len_q);
			err_s2  <= ex.err;
		end
		if (en_out) begin
			result_q.next_line      <= next_s2;
			result_q.wrote_register <= wr_s2;
			result_q.written_value  <= wr_s2 ? wval_s2 : '0;
			result_q.finished       <= fin_s2;
			result_q.error_code     <= err_s2;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// The pipeline stays empty until the memory clear is done.
	`MSE_ASSERT_ALWAYS(a_clear_empty, clr_busy_q |-> !valid_s1 && !valid_s2 && !result_valid_q, "instruction in flight during memory clear")
	// A held stage 1 must not see the register file change under its operands.
	`MSE_ASSERT(a_hold_no_write, valid_s1 && !en_s2 |-> !rf_wr.en, "register write while stage 1 holds")
	// An out-of-range access neither writes a register nor reports a value.
	`MSE_ASSERT(a_err_no_write, result_valid_q && result_q.error_code |-> !result_q.wrote_register && result_q.written_value == '0, "error result with register write")

endmodule

`default_nettype wire

[rtl/mse_regfile.sv]
// Register file: 32 words, two synchronous read ports, one write port.
// Entries never written read as zero; a read at the edge of a write returns the new data.
// Depends on mse_pkg.
`default_nettype none

module mse_regfile
	import mse_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  rd_en,
	input  wire logic [REG_ADDR_W-1:0] ra_addr,
	input  wire logic [REG_ADDR_W-1:0] rb_addr,
	output logic      [WORD_W-1:0]     ra_data,
	output logic      [WORD_W-1:0]     rb_data,
	input  wire rf_wr_t                wr
);

	logic [WORD_W-1:0]    mem [REG_COUNT];
	logic [REG_COUNT-1:0] vld_q;
	logic [WORD_W-1:0]    ma_q, mb_q, byp_q;
	logic                 va_q, vb_q, ha_q, hb_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			ma_q  <= mem[ra_addr];
			mb_q  <= mem[rb_addr];
			byp_q <= wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			va_q  <= 1'b0;
			vb_q  <= 1'b0;
			ha_q  <= 1'b0;
			hb_q  <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				va_q <= vld_q[ra_addr];
				vb_q <= vld_q[rb_addr];
				ha_q <= wr.en && (wr.addr == ra_addr);
				hb_q <= wr.en && (wr.addr == rb_addr);
			end
		end
	end

	assign ra_data = ha_q ? byp_q : (va_q ? ma_q : '0);
	assign rb_data = hb_q ? byp_q : (vb_q ? mb_q : '0);

endmodule

`default_nettype wire

[rtl/mse_alu.sv]
// Execute logic: ALU result, next line, register write and memory access decision.
// Purely combinational; depends on mse_pkg.
`default_nettype none

module mse_alu
	import mse_pkg::*;
#(
	parameter int MEM_WORDS = MEM_WORDS_DEF
)
(
	input  wire instr_t              instr,
	input  wire logic [WORD_W-1:0]   a,
	input  wire logic [WORD_W-1:0]   b,
	input  wire logic [LINE_W-1:0]   line,
	output exec_t                    ex
);

	localparam logic [WORD_W-1:0] MEM_LIMIT = WORD_W'(MEM_WORDS);

	always_comb begin
		logic [WORD_W-1:0] imm;
		logic [LINE_W-1:0] seq;
		logic [LINE_W-1:0] jump;
		imm  = instr.immediate;
		seq  = line + LINE_W'(1);
		jump = instr.target_line + LINE_W'(1);

		ex           = '0;
		ex.next_line = seq;
		ex.wr        = 1'b1;
		ex.wreg      = instr.dest_reg;

		case (instr.func)
			FN_ADD:   ex.val = a + b;
			FN_SUB:   ex.val = a - b;
			FN_OR:    ex.val = a | b;
			FN_AND:   ex.val = a & b;
			FN_XOR:   ex.val = a ^ b;
			FN_NOR:   ex.val = ~(a | b);
			FN_SLLV:  ex.val = a << b[4:0];
			FN_SRLV:  ex.val = a >> b[4:0];
			FN_SLT:   ex.val = WORD_W'($signed(a) < $signed(b));
			FN_ADDI:  ex.val = a + imm;
			FN_ANDI:  ex.val = a & imm;
			FN_ORI:   ex.val = a | imm;
			FN_XORI:  ex.val = a ^ imm;
			FN_NORI:  ex.val = ~(a | imm);
			FN_SLL:   ex.val = a << imm[4:0];
			FN_SRL:   ex.val = a >> imm[4:0];
			FN_SLTIU: ex.val = WORD_W'(a < imm);
			FN_J: begin
				ex.wr        = 1'b0;
				ex.next_line = jump;
			end
			FN_JR: begin
				ex.wr = 1'b0;
				// A negative target falls through to the next line.
				if (!a[WORD_W-1]) begin
					ex.next_line = a[LINE_W-1:0];
				end
			end
			FN_JAL: begin
				ex.wreg      = RETURN_REG;
				ex.val       = WORD_W'({1'b0, line} + (LINE_W+1)'(1));
				ex.next_line = jump;
			end
			FN_BEQ: begin
				ex.wr = 1'b0;
				if (a == b) begin
					ex.next_line = jump;
				end
			end
			FN_BNE: begin
				ex.wr = 1'b0;
				if (a != b) begin
					ex.next_line = jump;
				end
			end
			FN_LB: begin
				if (a >= MEM_LIMIT) begin
					ex.err = 1'b1;
					ex.wr  = 1'b0;
				end else begin
					ex.mem_rd = 1'b1;
				end
			end
			FN_SB: begin
				ex.wr = 1'b0;
				if (a >= MEM_LIMIT) begin
					ex.err = 1'b1;
				end else begin
					ex.mem_wr = 1'b1;
				end
			end
			default: ex.wr = 1'b0;
		endcase
	end

endmodule

`default_nettype wire
